// ----- rtl/abvh_pkg.sv -----
`default_nettype none
package abvh_pkg;
    // Node numbers, port field width and pad width are fixed by the interface.
    localparam int NODE_W  = 7;
    localparam int FIELD_W = 16;
    localparam int PAD_W   = 8;
    localparam int CORNER_W = 2;

    localparam logic [CORNER_W-1:0] CORNER_INNER = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_LAST  = 2'd3;

    localparam logic [PAD_W-1:0] PAD_RESET = 8'd1;
endpackage
`default_nettype wire

// ----- rtl/abvh_ram.sv -----
`default_nettype none
module abvh_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/agglomerative_bvh_builder_core.sv -----
`default_nettype none
// Channel   Direction  Handshake           Payload
// vertex    in         i_valid / o_stall   i_coord_x/y/z, i_corner, i_final_tetra
// parent    out        o_valid / i_stall   o_node_index, o_left_child, o_right_child,
//                                          o_box_min/max_x/y/z, o_last_parent
// config    in         i_cfg_wr_en         i_cfg_wr_data (degenerate pad)
//
// Vertices are taken one per cycle while the block is loading.
// An accepted item with final set starts clustering if the list then holds two
// or more leaves; each round scans all L*(L-1)/2 pairs of an L entry list at one
// pair per cycle through a volume pipeline, then compacts it and writes the parent.
// Reset is synchronous and active low; the list memories need no clearing.
// o_stall is high for the whole clustering run; a stalled parent holds the run.
module agglomerative_bvh_builder_core
    import abvh_pkg::*;
#(
    parameter int MAX_LEAVES = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [PAD_W-1:0]          i_cfg_wr_data,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic signed [FIELD_W-1:0] i_coord_x,
    input  wire logic signed [FIELD_W-1:0] i_coord_y,
    input  wire logic signed [FIELD_W-1:0] i_coord_z,
    input  wire logic [CORNER_W-1:0]       i_corner,
    input  wire logic                      i_final_tetra,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [NODE_W-1:0]              o_node_index,
    output logic [NODE_W-1:0]              o_left_child,
    output logic [NODE_W-1:0]              o_right_child,
    output logic signed [FIELD_W-1:0]      o_box_min_x,
    output logic signed [FIELD_W-1:0]      o_box_min_y,
    output logic signed [FIELD_W-1:0]      o_box_min_z,
    output logic signed [FIELD_W-1:0]      o_box_max_x,
    output logic signed [FIELD_W-1:0]      o_box_max_y,
    output logic signed [FIELD_W-1:0]      o_box_max_z,
    output logic                           o_last_parent
);
    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
    localparam int LW = $clog2(MAX_LEAVES + 1);
    localparam int EW = 6 * CB + NODE_W;
    localparam int SW = CB + 2;
    localparam logic signed [SW-1:0] C_MAX = SW'((1 << (CB - 1)) - 1);
    localparam logic signed [SW-1:0] C_MIN = -SW'(1 << (CB - 1));

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_PACK,
        S_PARENT
    } t_state;

    t_state r_state;

    logic [PAD_W-1:0] r_pad;
    logic [LW-1:0]    r_len;
    logic [NODE_W-1:0] r_nid;

    // Box of the tetrahedron being loaded.
    logic signed [CB-1:0] r_lo [3];
    logic signed [CB-1:0] r_hi [3];
    logic signed [CB-1:0] n_lo [3];
    logic signed [CB-1:0] n_hi [3];
    logic signed [CB-1:0] pad_lo [3];
    logic signed [CB-1:0] pad_hi [3];
    logic signed [CB-1:0] pt [3];

    // Pair scan counters and pipeline.
    logic [IW-1:0] r_i, r_j;
    logic          r1_v, r2_v, r3_v, r4_v;
    logic [IW-1:0] r1_i, r1_j, r2_i, r2_j, r3_i, r3_j, r4_i, r4_j;

    logic signed [CB-1:0] m_lo [3];
    logic signed [CB-1:0] m_hi [3];
    logic [CB-1:0]        m_ext [3];

    logic signed [CB-1:0] r2_lo [3];
    logic signed [CB-1:0] r2_hi [3];
    logic [CB-1:0]        r2_ext [3];
    logic [NODE_W-1:0]    r2_la, r2_lb;
    logic signed [CB-1:0] r3_lo [3];
    logic signed [CB-1:0] r3_hi [3];
    logic [2*CB-1:0]      r3_m;
    logic [CB-1:0]        r3_ez;
    logic [NODE_W-1:0]    r3_la, r3_lb;
    logic signed [CB-1:0] r4_lo [3];
    logic signed [CB-1:0] r4_hi [3];
    logic [3*CB-1:0]      r4_vol;
    logic [NODE_W-1:0]    r4_la, r4_lb;

    // Best pair so far.
    logic                 r_found;
    logic [3*CB-1:0]      r_best;
    logic [IW-1:0]        r_bi, r_bj;
    logic [NODE_W-1:0]    r_bla, r_blb;
    logic signed [CB-1:0] r_blo [3];
    logic signed [CB-1:0] r_bhi [3];

    // Compaction counters.
    logic [LW-1:0] r_t;
    logic [IW-1:0] r_w, r_td;
    logic          r_pv;

    // Memories: two copies of the list so that both entries of a pair are read together.
    logic          mem_we;
    logic [IW-1:0] mem_waddr, raddr_a, raddr_b;
    logic [EW-1:0] mem_wdata, q_a, q_b;

    logic acc, last_pair, out_free, keep;
    logic [LW-1:0] len_after;

    assign o_stall  = (r_state != S_LOAD);
    assign acc      = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    assign pt[0] = i_coord_x[CB-1:0];
    assign pt[1] = i_coord_y[CB-1:0];
    assign pt[2] = i_coord_z[CB-1:0];

    always_comb begin
        logic signed [SW-1:0] a, b;
        for (int k = 0; k < 3; k++) begin
            if (i_corner == CORNER_INNER) begin
                n_lo[k] = pt[k];
                n_hi[k] = pt[k];
            end else begin
                n_lo[k] = (pt[k] < r_lo[k]) ? pt[k] : r_lo[k];
                n_hi[k] = (pt[k] > r_hi[k]) ? pt[k] : r_hi[k];
            end
            a = SW'(n_lo[k]) - $signed({{(SW-PAD_W){1'b0}}, r_pad});
            b = SW'(n_hi[k]) + $signed({{(SW-PAD_W){1'b0}}, r_pad});
            if (a < C_MIN) a = C_MIN;
            if (b > C_MAX) b = C_MAX;
            if (n_lo[k] == n_hi[k]) begin
                pad_lo[k] = a[CB-1:0];
                pad_hi[k] = b[CB-1:0];
            end else begin
                pad_lo[k] = n_lo[k];
                pad_hi[k] = n_hi[k];
            end
        end
    end

    // Merged box of the pair read from the two memory copies.
    always_comb begin
        logic signed [CB-1:0] al, ah, bl, bh;
        logic [CB:0] d;
        for (int k = 0; k < 3; k++) begin
            al = q_a[k*CB +: CB];
            ah = q_a[(3+k)*CB +: CB];
            bl = q_b[k*CB +: CB];
            bh = q_b[(3+k)*CB +: CB];
            m_lo[k] = (al < bl) ? al : bl;
            m_hi[k] = (ah > bh) ? ah : bh;
            d = (CB+1)'(m_hi[k]) - (CB+1)'(m_lo[k]);
            m_ext[k] = d[CB-1:0];
        end
    end

    assign last_pair = ({{(LW-IW){1'b0}}, r_i} == r_len - LW'(2))
                    && ({{(LW-IW){1'b0}}, r_j} == r_len - LW'(1));
    assign keep = r_pv && (r_td != r_bi) && (r_td != r_bj);
    assign len_after = (i_corner == CORNER_LAST && r_len < LW'(MAX_LEAVES))
                     ? r_len + LW'(1) : r_len;

    always_comb begin
        raddr_a   = (r_state == S_PACK) ? r_t[IW-1:0] : r_i;
        raddr_b   = r_j;
        mem_we    = 1'b0;
        mem_waddr = r_len[IW-1:0];
        mem_wdata = {r_nid, pad_hi[2], pad_hi[1], pad_hi[0],
                     pad_lo[2], pad_lo[1], pad_lo[0]};
        unique case (r_state)
            S_LOAD: begin
                mem_we = acc && (i_corner == CORNER_LAST) && (r_len < LW'(MAX_LEAVES));
            end
            S_PACK: begin
                mem_we    = keep;
                mem_waddr = r_w;
                mem_wdata = q_a;
            end
            S_PARENT: begin
                mem_we    = out_free;
                mem_waddr = r_w;
                mem_wdata = {r_nid, r_bhi[2], r_bhi[1], r_bhi[0],
                             r_blo[2], r_blo[1], r_blo[0]};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    abvh_ram #(.W(EW), .D(MAX_LEAVES)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (raddr_a),
        .o_rdata (q_a)
    );

    abvh_ram #(.W(EW), .D(MAX_LEAVES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (raddr_b),
        .o_rdata (q_b)
    );

    // Volume pipeline payload; its valid bits live in the control block.
    always_ff @(posedge i_clk) begin
        r1_i <= r_i;
        r1_j <= r_j;
        r2_i <= r1_i;
        r2_j <= r1_j;
        r2_la <= q_a[6*CB +: NODE_W];
        r2_lb <= q_b[6*CB +: NODE_W];
        r2_lo <= m_lo;
        r2_hi <= m_hi;
        r2_ext <= m_ext;
        r3_i <= r2_i;
        r3_j <= r2_j;
        r3_la <= r2_la;
        r3_lb <= r2_lb;
        r3_lo <= r2_lo;
        r3_hi <= r2_hi;
        r3_m  <= (2*CB)'(r2_ext[0]) * (2*CB)'(r2_ext[1]);
        r3_ez <= r2_ext[2];
        r4_i <= r3_i;
        r4_j <= r3_j;
        r4_la <= r3_la;
        r4_lb <= r3_lb;
        r4_lo <= r3_lo;
        r4_hi <= r3_hi;
        r4_vol <= (3*CB)'(r3_m) * (3*CB)'(r3_ez);
        if (r4_v && (!r_found || r4_vol < r_best)) begin
            r_best <= r4_vol;
            r_bi   <= r4_i;
            r_bj   <= r4_j;
            r_bla  <= r4_la;
            r_blb  <= r4_lb;
            r_blo  <= r4_lo;
            r_bhi  <= r4_hi;
        end
        // The held box starts at zero so that outer vertices after reset widen it.
        if (!i_rst_n) begin
            r_lo <= '{default: '0};
            r_hi <= '{default: '0};
        end else if (r_state == S_LOAD && acc) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (r_state == S_PACK) begin
            r_td <= r_t[IW-1:0];
        end
        if (r_state == S_PARENT && out_free) begin
            o_node_index  <= r_nid;
            o_left_child  <= r_bla;
            o_right_child <= r_blb;
            o_box_min_x   <= FIELD_W'(r_blo[0]);
            o_box_min_y   <= FIELD_W'(r_blo[1]);
            o_box_min_z   <= FIELD_W'(r_blo[2]);
            o_box_max_x   <= FIELD_W'(r_bhi[0]);
            o_box_max_y   <= FIELD_W'(r_bhi[1]);
            o_box_max_z   <= FIELD_W'(r_bhi[2]);
            o_last_parent <= (r_len == LW'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pad   <= PAD_RESET;
            r_len   <= '0;
            r_nid   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_found <= 1'b0;
            r_t     <= '0;
            r_w     <= '0;
            r_pv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pad <= i_cfg_wr_data;
            end
            // The parent state sets the output valid itself.
            if (o_valid && !i_stall && r_state != S_PARENT) begin
                o_valid <= 1'b0;
            end
            r1_v <= (r_state == S_SCAN);
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            if (r4_v) begin
                r_found <= 1'b1;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (acc) begin
                        if (i_final_tetra && len_after <= LW'(1)) begin
                            // Fewer than two leaves: nothing to cluster.
                            r_len <= '0;
                            r_nid <= '0;
                        end else begin
                            if (mem_we) begin
                                r_nid <= r_nid + NODE_W'(1);
                            end
                            r_len <= len_after;
                            if (i_final_tetra) begin
                                r_state <= S_SCAN;
                                r_i     <= '0;
                                r_j     <= IW'(1);
                                r_found <= 1'b0;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (last_pair) begin
                        r_state <= S_DRAIN;
                    end else if ({{(LW-IW){1'b0}}, r_j} == r_len - LW'(1)) begin
                        r_i <= r_i + IW'(1);
                        r_j <= r_i + IW'(2);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r1_v && !r2_v && !r3_v && !r4_v) begin
                        r_state <= S_PACK;
                        r_t     <= '0;
                        r_w     <= '0;
                        r_pv    <= 1'b0;
                    end
                end
                S_PACK: begin
                    // Stream the list through and rewrite it without the chosen pair.
                    if (r_t < r_len) begin
                        r_t  <= r_t + LW'(1);
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (keep) begin
                        r_w <= r_w + IW'(1);
                    end
                    if (r_t == r_len && !r_pv) begin
                        r_state <= S_PARENT;
                    end
                end
                S_PARENT: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        if (r_len - LW'(1) > LW'(1)) begin
                            r_len   <= r_len - LW'(1);
                            r_nid   <= r_nid + NODE_W'(1);
                            r_state <= S_SCAN;
                            r_i     <= '0;
                            r_j     <= IW'(1);
                            r_found <= 1'b0;
                        end else begin
                            r_len   <= '0;
                            r_nid   <= '0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
